// ===== hw/rtl/ndef_record_framing_parser_macros.svh =====
// assertion macros used by the ndef record framing parser core
`ifndef NDEF_RECORD_FRAMING_PARSER_MACROS_SVH
`define NDEF_RECORD_FRAMING_PARSER_MACROS_SVH

// same-cycle implication, checked outside reset
`define NRFP_ASSERT_IMP(name, clk, rst_n, pre, post, msg) \
  name: assert property (@(posedge clk) disable iff (!(rst_n)) (pre) |-> (post)) \
    else $error(msg);

// next-cycle implication, checked outside reset
`define NRFP_ASSERT_NXT(name, clk, rst_n, pre, post, msg) \
  name: assert property (@(posedge clk) disable iff (!(rst_n)) (pre) |=> (post)) \
    else $error(msg);

`endif

// ===== hw/rtl/nrfp_pkg.sv =====
// types and constants of the ndef record framing parser
package nrfp_pkg;

  // parser phase, one-hot
  typedef enum logic [4:0] {
    PH_HDR   = 5'b00001,
    PH_TLEN  = 5'b00010,
    PH_PLEN  = 5'b00100,
    PH_IDLEN = 5'b01000,
    PH_BODY  = 5'b10000
  } phase_e;

  // result status codes
  typedef enum logic [1:0] {
    ST_COMPLETE = 2'd0,
    ST_OVERFLOW = 2'd1,
    ST_TRUNC    = 2'd2
  } status_e;

  // bit positions in the record flags byte
  localparam int unsigned FlagCf = 5;
  localparam int unsigned FlagSr = 4;
  localparam int unsigned FlagIl = 3;

  // bit of the length register that marks a length of 2^31 or more
  localparam int unsigned OverflowBit = 31;

  // type offset terms: flags + type length, then the length and id length bytes
  localparam logic [2:0] ToffBase  = 3'd2;
  localparam logic [2:0] ToffShort = 3'd1;
  localparam logic [2:0] ToffLong  = 3'd4;
  localparam logic [1:0] LenLastByte = 2'd3;

  localparam int unsigned DataOutWidth = 128;

  // one accepted input byte
  typedef struct packed {
    logic [7:0] data_byte;
    logic       block_end;
  } item_t;

  // one record descriptor or error
  typedef struct packed {
    status_e     status;
    logic [7:0]  header;
    logic [7:0]  type_len;
    logic [7:0]  id_len;
    logic [30:0] pay_len;
    logic [2:0]  type_off;
    logic [31:0] record_length;
    logic [31:0] record_start;
  } result_t;

endpackage

// ===== hw/rtl/nrfp_core.sv =====
// record header state machine, body counter and descriptor builder
`include "ndef_record_framing_parser_macros.svh"

module nrfp_core #(
  parameter int unsigned POS_WIDTH = 32
) (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             step_i,
  input  nrfp_pkg::item_t  item_i,
  output logic             has_result_o,
  output nrfp_pkg::result_t result_o
);
  import nrfp_pkg::*;

  phase_e                 phase_q, phase_d;
  logic [7:0]             flags_q, flags_d;
  logic [7:0]             tlen_q, tlen_d;
  logic [7:0]             idlen_q, idlen_d;
  logic [31:0]            plen_q, plen_d;
  logic [1:0]             lbc_q, lbc_d;
  logic [31:0]            rem_q, rem_d;
  logic [POS_WIDTH-1:0]   pos_q, pos_d;
  logic [POS_WIDTH-1:0]   start_q, start_d;
  logic                   stopped_q, stopped_d;

  logic        enter_body;
  logic        complete;
  logic        len_done;
  logic        overflow;
  logic        trunc;
  logic        emit_done;
  logic [31:0] body_sum;
  logic [2:0]  toff;

  // next state for one byte
  always_comb begin
    phase_d    = phase_q;
    flags_d    = flags_q;
    tlen_d     = tlen_q;
    idlen_d    = idlen_q;
    plen_d     = plen_q;
    lbc_d      = lbc_q;
    rem_d      = rem_q;
    start_d    = start_q;
    stopped_d  = stopped_q;
    enter_body = 1'b0;
    complete   = 1'b0;
    len_done   = 1'b0;
    overflow   = 1'b0;
    trunc      = 1'b0;

    if (!stopped_q) begin
      case (phase_q)
        PH_HDR: begin
          start_d = pos_q;
          flags_d = item_i.data_byte;
          tlen_d  = '0;
          idlen_d = '0;
          plen_d  = '0;
          lbc_d   = '0;
          rem_d   = '0;
          phase_d = PH_TLEN;
        end
        PH_TLEN: begin
          tlen_d  = item_i.data_byte;
          lbc_d   = '0;
          phase_d = PH_PLEN;
        end
        PH_PLEN: begin
          plen_d = {plen_q[23:0], item_i.data_byte};
          if (flags_q[FlagSr]) begin
            len_done = 1'b1;
          end else begin
            len_done = (lbc_q == LenLastByte);
            lbc_d    = lbc_q + 2'd1;
          end
          if (len_done) begin
            if (plen_d[OverflowBit]) begin
              overflow  = 1'b1;
              stopped_d = 1'b1;
            end else if (flags_q[FlagIl]) begin
              phase_d = PH_IDLEN;
            end else begin
              enter_body = 1'b1;
            end
          end
        end
        PH_IDLEN: begin
          idlen_d    = item_i.data_byte;
          enter_body = 1'b1;
        end
        PH_BODY: begin
          rem_d    = rem_q - {31'd0, (rem_q != 32'd0)};
          complete = (rem_d == 32'd0);
        end
        default: begin
          phase_d = PH_HDR;
        end
      endcase
    end

    // type, id and payload bytes still to come
    body_sum = 32'(tlen_d) + 32'(idlen_d) + plen_d;

    if (enter_body) begin
      rem_d = body_sum;
      if (body_sum == 32'd0) begin
        complete = 1'b1;
      end else begin
        phase_d = PH_BODY;
      end
    end

    if (complete) begin
      phase_d = PH_HDR;
    end
    emit_done = complete && !flags_d[FlagCf];

    // block ended inside a record
    if (item_i.block_end && !stopped_q && !stopped_d && phase_d != PH_HDR) begin
      trunc = 1'b1;
    end

    // rearm at block end
    if (item_i.block_end) begin
      phase_d   = PH_HDR;
      pos_d     = '0;
      lbc_d     = '0;
      rem_d     = '0;
      stopped_d = 1'b0;
    end else begin
      pos_d = pos_q + {{(POS_WIDTH-1){1'b0}}, 1'b1};
    end
  end

  // descriptor fields
  always_comb begin
    toff = ToffBase + (flags_d[FlagSr] ? ToffShort : ToffLong)
         + {2'd0, flags_d[FlagIl]};
    has_result_o = overflow || emit_done || trunc;
    if (overflow) begin
      result_o.status = ST_OVERFLOW;
    end else if (trunc) begin
      result_o.status = ST_TRUNC;
    end else begin
      result_o.status = ST_COMPLETE;
    end
    result_o.header         = flags_d;
    result_o.type_len       = tlen_d;
    result_o.id_len         = idlen_d;
    result_o.pay_len        = plen_d[30:0];
    result_o.type_off       = emit_done ? toff : 3'd0;
    result_o.record_length  = emit_done ? (32'(toff) + body_sum) : 32'd0;
    result_o.record_start   = 32'(start_d);
  end

  // state registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      phase_q   <= PH_HDR;
      flags_q   <= '0;
      tlen_q    <= '0;
      idlen_q   <= '0;
      plen_q    <= '0;
      lbc_q     <= '0;
      rem_q     <= '0;
      pos_q     <= '0;
      start_q   <= '0;
      stopped_q <= 1'b0;
    end else if (step_i) begin
      phase_q   <= phase_d;
      flags_q   <= flags_d;
      tlen_q    <= tlen_d;
      idlen_q   <= idlen_d;
      plen_q    <= plen_d;
      lbc_q     <= lbc_d;
      rem_q     <= rem_d;
      pos_q     <= pos_d;
      start_q   <= start_d;
      stopped_q <= stopped_d;
    end
  end

  `NRFP_ASSERT_IMP(a_stopped_silent, clk_i, rst_ni, step_i && stopped_q, !has_result_o, "result while stopped")
  `NRFP_ASSERT_IMP(a_body_nonzero, clk_i, rst_ni, phase_q == PH_BODY, rem_q != 32'd0, "body counter zero in body phase")
  `NRFP_ASSERT_NXT(a_block_rearm, clk_i, rst_ni, step_i && item_i.block_end, phase_q == PH_HDR && !stopped_q && pos_q == '0, "parser not rearmed after block end")

endmodule

// ===== hw/rtl/nrfp_out_reg.sv =====
// result register between the parser and the output stream
module nrfp_out_reg (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              load_i,
  input  nrfp_pkg::result_t data_i,
  input  logic              ready_i,
  output logic              valid_o,
  output nrfp_pkg::result_t data_o
);
  import nrfp_pkg::*;

  logic    valid_q;
  result_t data_q;

  // valid flag: set on load, cleared when taken
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else if (load_i) begin
      valid_q <= 1'b1;
    end else if (ready_i) begin
      valid_q <= 1'b0;
    end
  end

  // payload
  always_ff @(posedge clk_i) begin
    if (load_i) begin
      data_q <= data_i;
    end
  end

  assign valid_o = valid_q;
  assign data_o  = data_q;

endmodule

// ===== hw/rtl/ndef_record_framing_parser.sv =====
// Top level of the NDEF record framing parser: one message byte per request.
// A byte is held in the input register and its descriptor in the result register.
// Throughput: one byte per cycle while descriptors are taken; a descriptor left
// waiting stalls the parser, and the input register holds one more byte
// meanwhile.
// Reset: asynchronous, active low; clears the parser to expect a header byte.
module ndef_record_framing_parser #(
  parameter int unsigned POS_WIDTH = 32
) (
  input  logic         clk_i,
  input  logic         rst_ni,
  // input stream
  input  logic         s_axis_tvalid,
  output logic         s_axis_tready,
  input  logic [7:0]   s_axis_tdata,  // [7:0] data_byte
  input  logic         s_axis_tlast,  // block_end
  // output stream
  output logic         m_axis_tvalid,
  input  logic         m_axis_tready,
  output logic [127:0] m_axis_tdata,  // header, type length, id length,
                                      // payload length, type offset,
                                      // record_length, record_start, zero fill
  output logic [1:0]   m_axis_tuser   // status
);
  import nrfp_pkg::*;

  logic    in_valid_q;
  item_t   in_item_q;
  logic    advance;
  logic    has_result;
  result_t result;
  logic    out_valid;
  result_t out_data;

  // the parser step fires when a byte is held and the result register can take a result
  assign advance       = in_valid_q && (!out_valid || m_axis_tready);
  assign s_axis_tready = !in_valid_q || advance;

  // input register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_valid_q <= 1'b0;
    end else if (s_axis_tready) begin
      in_valid_q <= s_axis_tvalid;
    end
  end

  always_ff @(posedge clk_i) begin
    if (s_axis_tvalid && s_axis_tready) begin
      in_item_q.data_byte <= s_axis_tdata;
      in_item_q.block_end <= s_axis_tlast;
    end
  end

  nrfp_core #(
    .POS_WIDTH(POS_WIDTH)
  ) u_core (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .step_i       (advance),
    .item_i       (in_item_q),
    .has_result_o (has_result),
    .result_o     (result)
  );

  nrfp_out_reg u_out_reg (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .load_i  (advance && has_result),
    .data_i  (result),
    .ready_i (m_axis_tready),
    .valid_o (out_valid),
    .data_o  (out_data)
  );

  // output packing, first field lowest
  assign m_axis_tvalid = out_valid;
  assign m_axis_tuser  = out_data.status;
  assign m_axis_tdata  = {6'd0,
                          out_data.record_start,
                          out_data.record_length,
                          out_data.type_off,
                          out_data.pay_len,
                          out_data.id_len,
                          out_data.type_len,
                          out_data.header};

endmodule

// ===== tb/sv/ndef_record_framing_parser_tb.sv =====
// self-checking testbench of the ndef record framing parser
`timescale 1ns / 1ps

module ndef_record_framing_parser_tb;
  import nrfp_pkg::*;

  localparam int unsigned ItemTarget = 1550;
  localparam int unsigned LongHold   = 200;
  localparam int unsigned DrainWait  = 10;
  localparam int unsigned TimeoutNs  = 5_000_000;

  localparam result_t NoDesc = '0;

  // directed request with an optional hand-written descriptor
  typedef struct {
    logic [7:0] data;
    logic       last;
    bit         typed;
    result_t    want;
  } dir_row_t;

  logic         clk_i;
  logic         rst_ni;
  logic         s_axis_tvalid;
  logic         s_axis_tready;
  logic [7:0]   s_axis_tdata;
  logic         s_axis_tlast;
  logic         m_axis_tvalid;
  logic         m_axis_tready;
  logic [127:0] m_axis_tdata;
  logic [1:0]   m_axis_tuser;

  // parser state mirrored by the predictor
  phase_e       parse_phase = PH_HDR;
  logic [7:0]   hdr_q       = '0;
  logic [7:0]   tlen_q      = '0;
  logic [7:0]   idlen_q     = '0;
  logic [31:0]  plen_q      = '0;
  logic [1:0]   lencnt_q    = '0;
  logic [32:0]  body_left   = '0;
  logic [31:0]  pos_q       = '0;
  logic [31:0]  start_q     = '0;
  bit           halted      = 1'b0;

  result_t      pending_desc_q[$];
  logic [7:0]   blk_q[$];
  int unsigned  err_count   = 0;
  int unsigned  byte_count  = 0;
  int unsigned  block_count = 0;
  int unsigned  status_seen[3] = '{0, 0, 0};
  bit           fast_phase  = 1'b0;
  bit           hold_req    = 1'b0;

  // directed part: first block holds a record, a chunk and an overflow with ignored tail,
  // then a one-byte block and a block that overflows on its last byte
  dir_row_t dir_tbl [24] = '{
    '{8'hD1, 1'b0, 1'b0, NoDesc},
    '{8'h01, 1'b0, 1'b0, NoDesc},
    '{8'h01, 1'b0, 1'b0, NoDesc},
    '{8'h54, 1'b0, 1'b0, NoDesc},
    '{8'h00, 1'b0, 1'b1,
      result_t'{ST_COMPLETE, 8'hD1, 8'h01, 8'h00, 31'd1, 3'd3, 32'd5, 32'd0}},
    '{8'hFF, 1'b0, 1'b0, NoDesc},
    '{8'h00, 1'b0, 1'b0, NoDesc},
    '{8'h00, 1'b0, 1'b0, NoDesc},
    '{8'h00, 1'b0, 1'b0, NoDesc},
    '{8'h00, 1'b0, 1'b0, NoDesc},
    '{8'hFF, 1'b0, 1'b0, NoDesc},
    '{8'h80, 1'b0, 1'b0, NoDesc},
    '{8'h00, 1'b0, 1'b0, NoDesc},
    '{8'h00, 1'b0, 1'b0, NoDesc},
    '{8'h00, 1'b0, 1'b1,
      result_t'{ST_OVERFLOW, 8'h00, 8'hFF, 8'h00, 31'd0, 3'd0, 32'd0, 32'd9}},
    '{8'hFF, 1'b0, 1'b0, NoDesc},
    '{8'h00, 1'b1, 1'b0, NoDesc},
    '{8'h10, 1'b1, 1'b1,
      result_t'{ST_TRUNC, 8'h10, 8'h00, 8'h00, 31'd0, 3'd0, 32'd0, 32'd0}},
    '{8'h00, 1'b0, 1'b0, NoDesc},
    '{8'h00, 1'b0, 1'b0, NoDesc},
    '{8'hFF, 1'b0, 1'b0, NoDesc},
    '{8'hFF, 1'b0, 1'b0, NoDesc},
    '{8'hFF, 1'b0, 1'b0, NoDesc},
    '{8'hFF, 1'b1, 1'b1,
      result_t'{ST_OVERFLOW, 8'h00, 8'h00, 8'h00, 31'h7FFFFFFF, 3'd0, 32'd0, 32'd0}}
  };

  ndef_record_framing_parser u_dut (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (s_axis_tdata),
    .s_axis_tlast  (s_axis_tlast),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata),
    .m_axis_tuser  (m_axis_tuser)
  );

  // clock
  initial clk_i = 1'b0;
  always #5 clk_i = ~clk_i;

  // descriptor built from the record read so far
  function automatic result_t make_desc(input status_e st, input bit complete);
    result_t    r;
    logic [2:0] toff;
    r = '0;
    r.status         = st;
    r.header         = hdr_q;
    r.type_len       = tlen_q;
    r.id_len         = idlen_q;
    r.pay_len        = plen_q[30:0];
    r.record_start   = start_q;
    if (complete) begin
      toff = ToffBase + (hdr_q[FlagSr] ? ToffShort : ToffLong) + (hdr_q[FlagIl] ? 3'd1 : 3'd0);
      r.type_off      = toff;
      r.record_length = 32'(toff) + 32'(tlen_q) + 32'(idlen_q) + plen_q;
    end
    return r;
  endfunction

  // advance the parser by one byte; returns 1 when a descriptor is due
  function automatic bit parse_byte(input logic [7:0] b, input logic last,
                                    output result_t r);
    bit has;
    bit enter_body;
    bit complete;
    bit done;
    has = 1'b0;
    enter_body = 1'b0;
    complete = 1'b0;
    done = 1'b0;
    r = '0;
    if (!halted) begin
      case (parse_phase)
        PH_HDR: begin
          start_q     = pos_q;
          hdr_q       = b;
          tlen_q      = '0;
          idlen_q     = '0;
          plen_q      = '0;
          lencnt_q    = '0;
          body_left   = '0;
          parse_phase = PH_TLEN;
        end
        PH_TLEN: begin
          tlen_q      = b;
          lencnt_q    = '0;
          parse_phase = PH_PLEN;
        end
        PH_PLEN: begin
          plen_q = {plen_q[23:0], b};
          if (hdr_q[FlagSr]) begin
            done = 1'b1;
          end else begin
            done = (lencnt_q == LenLastByte);
            lencnt_q = lencnt_q + 2'd1;
          end
          if (done) begin
            if (plen_q[OverflowBit]) begin
              r = make_desc(ST_OVERFLOW, 1'b0);
              has = 1'b1;
              halted = 1'b1;
            end else if (hdr_q[FlagIl]) begin
              parse_phase = PH_IDLEN;
            end else begin
              enter_body = 1'b1;
            end
          end
        end
        PH_IDLEN: begin
          idlen_q = b;
          enter_body = 1'b1;
        end
        default: begin
          if (body_left != 0) body_left = body_left - 33'd1;
          if (body_left == 0) complete = 1'b1;
        end
      endcase
      if (enter_body) begin
        body_left = 33'(tlen_q) + 33'(idlen_q) + 33'(plen_q);
        if (body_left == 0) complete = 1'b1;
        else parse_phase = PH_BODY;
      end
      // completed chunks are parsed but never reported
      if (complete) begin
        parse_phase = PH_HDR;
        if (!hdr_q[FlagCf]) begin
          r = make_desc(ST_COMPLETE, 1'b1);
          has = 1'b1;
        end
      end
      if (last && !halted && parse_phase != PH_HDR) begin
        r = make_desc(ST_TRUNC, 1'b0);
        has = 1'b1;
      end
    end
    // every block end rearms the parser
    if (last) begin
      parse_phase = PH_HDR;
      pos_q       = '0;
      lencnt_q    = '0;
      body_left   = '0;
      halted      = 1'b0;
    end else begin
      pos_q = pos_q + 32'd1;
    end
    return has;
  endfunction

  // field length, mostly small with a rare maximum
  function automatic int unsigned pick_len();
    return ($urandom_range(0, 49) == 0) ? 255 : $urandom_range(0, 3);
  endfunction

  // append one record with random flags and content to the block buffer
  function automatic void append_record(input bit overflow);
    logic [7:0]  flags;
    int unsigned tl;
    int unsigned il;
    logic [31:0] pl;
    flags = 8'($urandom_range(0, 255));
    flags[FlagCf] = ($urandom_range(0, 3) == 0);
    if (overflow) flags[FlagSr] = 1'b0;
    tl = pick_len();
    il = flags[FlagIl] ? pick_len() : 0;
    if (flags[FlagSr])
      pl = ($urandom_range(0, 19) == 0) ? $urandom_range(0, 255) : $urandom_range(0, 8);
    else
      pl = ($urandom_range(0, 19) == 0) ? $urandom_range(256, 700) : $urandom_range(0, 12);
    blk_q.push_back(flags);
    blk_q.push_back(8'(tl));
    if (overflow) begin
      blk_q.push_back(8'($urandom_range(128, 255)));
      repeat (3) blk_q.push_back(8'($urandom_range(0, 255)));
      return;
    end
    if (flags[FlagSr]) begin
      blk_q.push_back(pl[7:0]);
    end else begin
      blk_q.push_back(pl[31:24]);
      blk_q.push_back(pl[23:16]);
      blk_q.push_back(pl[15:8]);
      blk_q.push_back(pl[7:0]);
    end
    if (flags[FlagIl]) blk_q.push_back(8'(il));
    for (int k = 0; k < tl + il + pl; k++) blk_q.push_back(8'($urandom_range(0, 255)));
  endfunction

  // offer one byte, wait for its handshake and log what it should produce
  task automatic send_byte(input logic [7:0] b, input logic last, input bit typed,
                           input result_t want);
    int unsigned gap;
    result_t     r;
    gap = fast_phase ? 0 : $urandom_range(0, 5);
    @(negedge clk_i);
    if (gap > 0) begin
      s_axis_tvalid <= 1'b0;
      repeat (gap) @(negedge clk_i);
    end
    s_axis_tvalid <= 1'b1;
    s_axis_tdata  <= b;
    s_axis_tlast  <= last;
    do @(posedge clk_i); while (!s_axis_tready);
    byte_count++;
    if (parse_byte(b, last, r) && !typed) pending_desc_q.push_back(r);
    if (typed) pending_desc_q.push_back(want);
  endtask

  // send the buffered block with the end flag on its last byte
  task automatic send_block();
    for (int i = 0; i < blk_q.size(); i++)
      send_byte(blk_q[i], i == blk_q.size() - 1, 1'b0, NoDesc);
    blk_q.delete();
    block_count++;
  endtask

  task automatic check_field(input string name, input logic [31:0] want,
                             input logic [31:0] got);
    if (got !== want) begin
      $display("%0t: %s expected 0x%0h, got 0x%0h", $time, name, want, got);
      err_count++;
    end
  endtask

  // output side: random stalls per request, one long hold on demand
  initial begin
    int unsigned stall;
    m_axis_tready = 1'b0;
    @(posedge rst_ni);
    forever begin
      @(negedge clk_i);
      if (hold_req) begin
        hold_req = 1'b0;
        m_axis_tready <= 1'b0;
        repeat (LongHold) @(negedge clk_i);
      end
      stall = fast_phase ? 0 : $urandom_range(0, 5);
      if (stall > 0) begin
        m_axis_tready <= 1'b0;
        repeat (stall) @(negedge clk_i);
      end
      m_axis_tready <= 1'b1;
      do @(posedge clk_i); while (!m_axis_tvalid);
    end
  end

  // compare each descriptor with the oldest one predicted
  always @(posedge clk_i) begin : desc_check
    result_t want;
    result_t got;
    if (rst_ni && m_axis_tvalid && m_axis_tready) begin
      got.status         = status_e'(m_axis_tuser);
      got.header         = m_axis_tdata[7:0];
      got.type_len       = m_axis_tdata[15:8];
      got.id_len         = m_axis_tdata[23:16];
      got.pay_len        = m_axis_tdata[54:24];
      got.type_off       = m_axis_tdata[57:55];
      got.record_length  = m_axis_tdata[89:58];
      got.record_start   = m_axis_tdata[121:90];
      if (pending_desc_q.size() == 0) begin
        $display("%0t: descriptor with none expected, status %0d header 0x%0h start %0d",
                 $time, m_axis_tuser, got.header, got.record_start);
        err_count++;
      end else begin
        want = pending_desc_q.pop_front();
        if (want.status <= ST_TRUNC) status_seen[want.status]++;
        check_field("status", 32'(want.status), 32'(got.status));
        check_field("header", 32'(want.header), 32'(got.header));
        check_field("type_len", 32'(want.type_len), 32'(got.type_len));
        check_field("id_len", 32'(want.id_len), 32'(got.id_len));
        check_field("pay_len", 32'(want.pay_len), 32'(got.pay_len));
        check_field("type_off", 32'(want.type_off), 32'(got.type_off));
        check_field("record_length", want.record_length, got.record_length);
        check_field("record_start", want.record_start, got.record_start);
        check_field("zero fill", 32'd0, 32'(m_axis_tdata[127:122]));
      end
    end
  end

  // run limit
  initial begin
    #(TimeoutNs);
    $display("timeout with %0d descriptors outstanding", pending_desc_q.size());
    $display("ndef_record_framing_parser: mismatch");
    $finish;
  end

  // stimulus
  initial begin
    int unsigned kind;
    int unsigned blk_idx;
    int unsigned drop;
    rst_ni        = 1'b0;
    s_axis_tvalid = 1'b0;
    s_axis_tdata  = '0;
    s_axis_tlast  = 1'b0;
    blk_idx       = 0;
    repeat (4) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni = 1'b1;

    // directed rows
    foreach (dir_tbl[i]) begin
      send_byte(dir_tbl[i].data, dir_tbl[i].last, dir_tbl[i].typed, dir_tbl[i].want);
      if (dir_tbl[i].last) block_count++;
    end

    // random blocks, mostly well formed
    while (byte_count < ItemTarget || blk_idx < 8) begin
      blk_idx++;
      fast_phase = ($urandom_range(0, 5) == 0);
      if (blk_idx == 4) begin
        // empty records back to back while the output is held off
        fast_phase = 1'b0;
        hold_req = 1'b1;
        repeat (30) begin
          blk_q.push_back({2'($urandom_range(0, 3)), 3'b010, 3'($urandom_range(0, 7))});
          blk_q.push_back(8'h00);
          blk_q.push_back(8'h00);
        end
      end else begin
        if (blk_idx == 8) begin
          // let everything drain before going on
          @(negedge clk_i);
          s_axis_tvalid <= 1'b0;
          while (pending_desc_q.size() != 0) @(posedge clk_i);
        end
        kind = $urandom_range(0, 99);
        if (kind < 70) begin
          repeat ($urandom_range(1, 4)) append_record(1'b0);
        end else if (kind < 82) begin
          repeat ($urandom_range(1, 3)) append_record(1'b0);
          if (blk_q.size() > 1) begin
            drop = $urandom_range(1, blk_q.size() - 1);
            repeat (drop) void'(blk_q.pop_back());
          end
        end else if (kind < 90) begin
          repeat ($urandom_range(0, 2)) append_record(1'b0);
          append_record(1'b1);
          repeat ($urandom_range(0, 5)) blk_q.push_back(8'($urandom_range(0, 255)));
        end else begin
          repeat ($urandom_range(1, 8)) blk_q.push_back(8'($urandom_range(0, 255)));
        end
      end
      send_block();
    end
    @(negedge clk_i);
    s_axis_tvalid <= 1'b0;

    // drain
    while (pending_desc_q.size() != 0) @(posedge clk_i);
    repeat (DrainWait) @(posedge clk_i);

    $display("sent %0d bytes in %0d blocks, with long output hold and a full drain pause",
             byte_count, block_count);
    $display("checked %0d complete records, %0d length overflows, %0d truncated blocks",
             status_seen[0], status_seen[1], status_seen[2]);
    if (err_count == 0) begin
      $display("ndef_record_framing_parser: match");
    end else begin
      $display("ndef_record_framing_parser: mismatch");
    end
    $finish;
  end

endmodule
